>>> rtl/core/termcap_bell_escape_decoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the termcap bell escape decoder
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef TERMCAP_BELL_ESCAPE_DECODER_ASSERT_SVH
`define TERMCAP_BELL_ESCAPE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define TBED_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");
`define TBED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`define TBED_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define TBED_ASSERT_NEVER(lbl, cond)
`define TBED_ASSERT_NEXT(lbl, ante, cons)
`define TBED_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

>>> rtl/core/tbed_pkg.sv
// ---------------------------------------------------------------------------
// tbed_pkg
// Types and constants shared by the bell escape decoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package tbed_pkg;

  localparam int unsigned CountW = 8;
  localparam logic [CountW-1:0] MaxFieldLen = 8'd255;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] KeyV      = 8'h76;
  localparam logic [7:0] KeyB      = 8'h62;
  localparam logic [7:0] KeyEq     = 8'h3D;
  localparam logic [7:0] Caret     = 8'h5E;
  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] Colon     = 8'h3A;
  localparam logic [7:0] Digit0    = 8'h30;
  localparam logic [7:0] Digit9    = 8'h39;
  localparam logic [7:0] CaretBias = 8'h40;
  localparam logic [7:0] BelByte   = 8'h07;
  localparam logic [7:0] EscByte   = 8'h1B;
  localparam logic [7:0] CrByte    = 8'h0D;
  localparam logic [7:0] LfByte    = 8'h0A;
  localparam logic [7:0] BsByte    = 8'h08;
  localparam logic [7:0] FfByte    = 8'h0C;
  localparam logic [7:0] TabByte   = 8'h09;
  localparam logic [7:0] ChE       = 8'h45;
  localparam logic [7:0] ChR       = 8'h72;
  localparam logic [7:0] ChN       = 8'h6E;
  localparam logic [7:0] ChB       = 8'h62;
  localparam logic [7:0] ChF       = 8'h66;
  localparam logic [7:0] ChT       = 8'h74;

  typedef enum logic [1:0] {
    PhSearch,
    PhField,
    PhDone
  } phase_e;

  typedef enum logic [1:0] {
    EscNormal,
    EscCaret,
    EscBack,
    EscDigits
  } esc_e;

  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } res_t;

  typedef struct packed {
    phase_e phase;
    esc_e   esc;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/termcap_bell_escape_decoder.sv
// ---------------------------------------------------------------------------
// termcap_bell_escape_decoder
// Scans capability text for the visual bell field and emits its decoded bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one text byte per beat in s_axis_tdata; s_axis_tuser high
//   marks end of text (a zero byte counts as end too). Master stream: one
//   decoded byte per beat in m_axis_tdata, m_axis_tlast high on the final
//   byte caused by an input beat.
//   Results are registered in the result queue before they reach the master
//   side. Throughput: one input beat per cycle while s_axis_tready is high;
//   an input beat gives zero, one or two output beats; the output side drains
//   one per cycle while m_axis_tready is high, through a four-entry result queue.
//   s_axis_tready is high while the queue holds two or fewer bytes; a
//   stalled receiver holds off the sender once three or four bytes wait,
//   and beats that give no byte pass until then.
//   Reset clears the scan state and empties the queue; no clearing pass.
//   End of text flushes a pending backslash or digit escape (drops a caret),
//   sends BEL if the field was empty or missing, and re-arms the next scan.
// ---------------------------------------------------------------------------
`default_nettype none

`include "termcap_bell_escape_decoder_assert.svh"

module termcap_bell_escape_decoder
  import tbed_pkg::*;
#(
  parameter logic [CountW-1:0] FieldLimit = MaxFieldLen
)
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] text_byte
  input  wire logic       s_axis_tuser,  // [0] action
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
  output logic            m_axis_tlast
);

  logic             take;
  res_t             res;
  stat_t            stat;
  logic [QCntW-1:0] qcount;

  assign take = s_axis_tvalid && s_axis_tready;

  tbed_decode #(
    .FieldLimit (FieldLimit)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .action_i (s_axis_tuser),
    .byte_i   (s_axis_tdata),
    .res_o    (res),
    .stat_o   (stat)
  );

  tbed_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .res_i   (res),
    .room_o  (s_axis_tready),
    .count_o (qcount),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  `TBED_ASSERT_NEVER(a_queue_bound, qcount > QCntW'(QDepth))
  `TBED_ASSERT_IMPL(a_esc_in_field, stat.esc != EscNormal, stat.phase == PhField)
  `TBED_ASSERT_NEXT(a_bell_on_missing, take && s_axis_tuser && stat.phase == PhSearch, m_axis_tvalid)
  `TBED_ASSERT_NEVER(a_no_results_when_done, take && stat.phase == PhDone && res.n != 2'd0)

endmodule

`default_nettype wire

>>> rtl/core/tbed_decode.sv
// ---------------------------------------------------------------------------
// tbed_decode
// Scan state and per-byte decode; yields up to two result bytes per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module tbed_decode
  import tbed_pkg::*;
#(
  parameter logic [CountW-1:0] FieldLimit = MaxFieldLen
)
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic       action_i,
  input  wire logic [7:0] byte_i,
  output res_t            res_o,
  output stat_t           stat_o
);

  phase_e            phase_q, phase_d;
  logic [1:0]        match_q, match_d;
  esc_e              esc_q, esc_d;
  logic [6:0]        acc_q, acc_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  function automatic res_t put(res_t r, logic [7:0] b);
    res_t o;
    o = r;
    if (r.n == 2'd0) begin
      o.b0 = b;
      o.n  = 2'd1;
    end else if (r.n == 2'd1) begin
      o.b1 = b;
      o.n  = 2'd2;
    end
    return o;
  endfunction

  function automatic res_t finish(res_t r, esc_e e, logic [6:0] a, logic [CountW-1:0] c);
    res_t o;
    o = r;
    if (e == EscBack) o = put(o, 8'h00);
    else if (e == EscDigits) o = put(o, {1'b0, a});
    if (c == '0) o = put(o, BelByte);
    return o;
  endfunction

  logic       digit;
  logic [7:0] dval;
  logic [7:0] key;
  logic [1:0] p;
  logic       plain;
  res_t       res;

  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    esc_d   = esc_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    res     = '0;
    plain   = 1'b0;
    digit   = (byte_i >= Digit0) && (byte_i <= Digit9);
    dval    = byte_i - Digit0;
    p       = (match_q == 2'd3) ? 2'd0 : match_q;
    key     = (p == 2'd0) ? KeyV : ((p == 2'd1) ? KeyB : KeyEq);
    if (take_i) begin
      if (action_i || byte_i == 8'h00) begin
        if (phase_q == PhSearch) res = put(res, BelByte);
        else if (phase_q == PhField) res = finish(res, esc_q, acc_q, cnt_q);
        phase_d = PhSearch;
        match_d = 2'd0;
        esc_d   = EscNormal;
        acc_d   = '0;
        cnt_d   = '0;
      end else begin
        unique case (phase_q)
          PhSearch: begin
            if (byte_i == key) p = p + 2'd1;
            else p = (byte_i == KeyV) ? 2'd1 : 2'd0;
            if (p == 2'd3) begin
              phase_d = PhField;
              match_d = 2'd0;
            end else begin
              match_d = p;
            end
          end
          PhField: begin
            if (byte_i == Colon) begin
              res     = finish(res, esc_q, acc_q, cnt_q);
              esc_d   = EscNormal;
              acc_d   = '0;
              phase_d = PhDone;
            end else if (cnt_q < FieldLimit) begin
              cnt_d = cnt_q + 1'b1;
              unique case (esc_q)
                EscCaret: begin
                  res   = put(res, byte_i - CaretBias);
                  esc_d = EscNormal;
                end
                EscBack: begin
                  esc_d = EscNormal;
                  case (byte_i)
                    ChE:       res = put(res, EscByte);
                    ChR:       res = put(res, CrByte);
                    ChN:       res = put(res, LfByte);
                    ChB:       res = put(res, BsByte);
                    ChF:       res = put(res, FfByte);
                    ChT:       res = put(res, TabByte);
                    Backslash: res = put(res, Backslash);
                    default: begin
                      if (digit) begin
                        acc_d = dval[6:0];
                        esc_d = EscDigits;
                      end else begin
                        res   = put(res, 8'h00);
                        plain = 1'b1;
                      end
                    end
                  endcase
                end
                EscDigits: begin
                  if (digit) begin
                    acc_d = {acc_q[3:0], 3'b000} + dval[6:0];
                  end else begin
                    res   = put(res, {1'b0, acc_q});
                    acc_d = '0;
                    esc_d = EscNormal;
                    plain = 1'b1;
                  end
                end
                default: plain = 1'b1;
              endcase
            end
          end
          default: ;
        endcase
        if (plain) begin
          if (byte_i == Caret) esc_d = EscCaret;
          else if (byte_i == Backslash) esc_d = EscBack;
          else res = put(res, byte_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSearch;
      match_q <= 2'd0;
      esc_q   <= EscNormal;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      match_q <= match_d;
      esc_q   <= esc_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  assign res_o  = res;
  assign stat_o = '{phase: phase_q, esc: esc_q};

endmodule

`default_nettype wire

>>> rtl/core/tbed_outq.sv
// ---------------------------------------------------------------------------
// tbed_outq
// Result queue: takes up to two bytes per beat, drains one per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module tbed_outq
  import tbed_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  res_t                  res_i,
  output logic                  room_o,
  output logic [QCntW-1:0]      count_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [7:0]            byte_o,
  output logic                  last_o
);

  logic [8:0]       ent_q [QDepth];
  logic [8:0]       ent_d [QDepth];
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QCntW-1:0] base;
  logic             pop;
  logic [1:0]       n;

  assign pop  = valid_o && ready_i;
  assign n    = push_i ? res_i.n : 2'd0;
  assign base = cnt_q - QCntW'(pop);

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (pop && i < QDepth - 1) ent_d[i] = ent_q[(i + 1) % QDepth];
      else ent_d[i] = ent_q[i];
      if (n != 2'd0 && base == QCntW'(i)) ent_d[i] = {res_i.b0, n == 2'd1};
      if (n == 2'd2 && base + 1'b1 == QCntW'(i)) ent_d[i] = {res_i.b1, 1'b1};
    end
    cnt_d = base + QCntW'(n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  assign room_o  = cnt_q <= QCntW'(QDepth - 2);
  assign count_o = cnt_q;
  assign valid_o = cnt_q != '0;
  assign byte_o  = ent_q[0][8:1];
  assign last_o  = ent_q[0][0];

endmodule

`default_nettype wire
